[sv/dtnf_pkg.sv]
// ----------------------------------------------------------------------------
// dtnf_pkg
// Shared widths, constants and the decimal scale table for the decimal
// fraction to normalized float converter.
// ----------------------------------------------------------------------------
package dtnf_pkg;

  // field widths
  localparam int INT_W   = 32;
  localparam int FRAC_W  = 32;
  localparam int DC_W    = 4;
  localparam int MANT_W  = 64;
  localparam int EXP_W   = 11;
  // 10^9 fits in 30 bits
  localparam int SCALE_W = 30;

  // number of binary fraction bits, one restoring step each
  localparam int FRAC_BITS = 32;

  // exponent bias, also the value for a zero mantissa, and start value
  localparam logic [EXP_W-1:0] EXP_BIAS  = 11'd1024;
  localparam logic [EXP_W-1:0] EXP_START = 11'd1055;

  // 10^digits, digit count saturated at nine
  function automatic logic [SCALE_W-1:0] scale_for(input logic [DC_W-1:0] digits);
    logic [SCALE_W-1:0] s;
    case (digits)
      4'd0:    s = 30'd1;
      4'd1:    s = 30'd10;
      4'd2:    s = 30'd100;
      4'd3:    s = 30'd1000;
      4'd4:    s = 30'd10000;
      4'd5:    s = 30'd100000;
      4'd6:    s = 30'd1000000;
      4'd7:    s = 30'd10000000;
      4'd8:    s = 30'd100000000;
      default: s = 30'd1000000000;
    endcase
    return s;
  endfunction

endpackage

[sv/dtnf_divider.sv]
// ----------------------------------------------------------------------------
// dtnf_divider
// Scale lookup stage followed by one register stage per restoring division
// step; produces the raw 64-bit mantissa (integer part over fraction bits).
// ----------------------------------------------------------------------------
module dtnf_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dtnf_pkg::INT_W-1:0]    integer_part,
  input  logic [dtnf_pkg::FRAC_W-1:0]   fraction_value,
  input  logic [dtnf_pkg::DC_W-1:0]     digit_count,
  output logic                          out_valid,
  output logic [dtnf_pkg::MANT_W-1:0]   out_mant
);
  import dtnf_pkg::*;

  // per-stage registers, stage 0 holds the captured input and its scale
  logic                 valid_q [0:FRAC_BITS];
  logic [INT_W-1:0]     ip_q    [0:FRAC_BITS];
  logic [FRAC_W-1:0]    rem_q   [0:FRAC_BITS];
  logic [FRAC_W-1:0]    bits_q  [0:FRAC_BITS];
  logic [SCALE_W-1:0]   scale_q [0:FRAC_BITS];

  // input capture with scale table lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip_q[0]    <= integer_part;
      rem_q[0]   <= fraction_value;
      bits_q[0]  <= '0;
      scale_q[0] <= scale_for(digit_count);
    end
  end

  // one restoring step per stage, remainder wraps at 32 bits
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [FRAC_W:0]   doubled;
    logic              take;
    logic [FRAC_W-1:0] rem_next;

    always_comb begin
      doubled  = {rem_q[k-1], 1'b0};
      take     = ({{(FRAC_W+1-SCALE_W){1'b0}}, scale_q[k-1]} <= doubled);
      rem_next = take ? (doubled[FRAC_W-1:0] - {{(FRAC_W-SCALE_W){1'b0}}, scale_q[k-1]})
                      : doubled[FRAC_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ip_q[k]    <= ip_q[k-1];
        rem_q[k]   <= rem_next;
        bits_q[k]  <= {bits_q[k-1][FRAC_W-2:0], take};
        scale_q[k] <= scale_q[k-1];
      end
    end
  end

  assign out_valid = valid_q[FRAC_BITS];
  assign out_mant  = {ip_q[FRAC_BITS], bits_q[FRAC_BITS]};

endmodule

[sv/dtnf_normalizer.sv]
// ----------------------------------------------------------------------------
// dtnf_normalizer
// Three-stage left shifter that normalizes a nonzero mantissa so bit 63 is set,
// two shift steps per stage, and tracks the biased exponent.
// ----------------------------------------------------------------------------
module dtnf_normalizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dtnf_pkg::MANT_W-1:0]   in_mant,
  output logic                          out_valid,
  output logic [dtnf_pkg::MANT_W-1:0]   mantissa,
  output logic [dtnf_pkg::EXP_W-1:0]    biased_exponent
);
  import dtnf_pkg::*;

  localparam int NSTAGE = 3;

  logic               valid_q [0:NSTAGE-1];
  logic [MANT_W-1:0]  mant_q  [0:NSTAGE-1];
  logic [EXP_W-1:0]   exp_q   [0:NSTAGE-1];

  logic [MANT_W-1:0]  m_a, m_b, m_c, m_d, m_e, m_f;
  logic [EXP_W-1:0]   e_a, e_b, e_c, e_d, e_e, e_f;

  // stage 1: shifts by 32 and 16
  always_comb begin
    if (in_mant[63:32] == '0) begin
      m_a = {in_mant[31:0], 32'd0};
      e_a = EXP_START - 11'd32;
    end else begin
      m_a = in_mant;
      e_a = EXP_START;
    end
    if (m_a[63:48] == '0) begin
      m_b = {m_a[47:0], 16'd0};
      e_b = e_a - 11'd16;
    end else begin
      m_b = m_a;
      e_b = e_a;
    end
  end

  // stage 2: shifts by 8 and 4
  always_comb begin
    if (mant_q[0][63:56] == '0) begin
      m_c = {mant_q[0][55:0], 8'd0};
      e_c = exp_q[0] - 11'd8;
    end else begin
      m_c = mant_q[0];
      e_c = exp_q[0];
    end
    if (m_c[63:60] == '0) begin
      m_d = {m_c[59:0], 4'd0};
      e_d = e_c - 11'd4;
    end else begin
      m_d = m_c;
      e_d = e_c;
    end
  end

  // stage 3: shifts by 2 and 1, zero mantissa gets the bias as exponent
  always_comb begin
    if (mant_q[1][63:62] == '0) begin
      m_e = {mant_q[1][61:0], 2'd0};
      e_e = exp_q[1] - 11'd2;
    end else begin
      m_e = mant_q[1];
      e_e = exp_q[1];
    end
    if (!m_e[63]) begin
      m_f = {m_e[62:0], 1'b0};
      e_f = e_e - 11'd1;
    end else begin
      m_f = m_e;
      e_f = e_e;
    end
    if (!m_f[63]) begin
      e_f = EXP_BIAS;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
      valid_q[2] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
      valid_q[1] <= valid_q[0];
      valid_q[2] <= valid_q[1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      mant_q[0] <= m_b;
      exp_q[0]  <= e_b;
      mant_q[1] <= m_d;
      exp_q[1]  <= e_d;
      mant_q[2] <= m_f;
      exp_q[2]  <= e_f;
    end
  end

  assign out_valid       = valid_q[NSTAGE-1];
  assign mantissa        = mant_q[NSTAGE-1];
  assign biased_exponent = exp_q[NSTAGE-1];

endmodule

[sv/decimal_to_normalized_float.sv]
// ----------------------------------------------------------------------------
// decimal_to_normalized_float
// Converts a whole-number part plus a decimal fraction into a normalized
// 64-bit mantissa and an 11-bit exponent with bias 1024.
//
//   channel  signals                                     direction
//   in       in_valid/in_ready, integer_part,             into block
//            fraction_value, digit_count
//   out      out_valid/out_ready, mantissa,               out of block
//            biased_exponent
//
// One transfer in and one out per cycle while out_ready stays high; a result
// passes through the scale lookup, 32 division step stages, 3 normalize
// stages and the output register.
// Synchronous reset clears the valid bits only.
// An output stall parks one result in a skid register, then freezes the
// whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module decimal_to_normalized_float (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtnf_pkg::INT_W-1:0]    integer_part,
  input  logic [dtnf_pkg::FRAC_W-1:0]   fraction_value,
  input  logic [dtnf_pkg::DC_W-1:0]     digit_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtnf_pkg::MANT_W-1:0]   mantissa,
  output logic [dtnf_pkg::EXP_W-1:0]    biased_exponent
);
  import dtnf_pkg::*;

  logic               en;
  logic               div_valid;
  logic [MANT_W-1:0]  div_mant;
  logic               norm_valid;
  logic [MANT_W-1:0]  norm_mant;
  logic [EXP_W-1:0]   norm_exp;

  logic               skid_valid;
  logic [MANT_W-1:0]  skid_mant;
  logic [EXP_W-1:0]   skid_exp;

  // pipeline moves whenever the skid register is empty
  assign en       = !skid_valid;
  assign in_ready = en;

  dtnf_divider u_divider (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .integer_part   (integer_part),
    .fraction_value (fraction_value),
    .digit_count    (digit_count),
    .out_valid      (div_valid),
    .out_mant       (div_mant)
  );

  dtnf_normalizer u_normalizer (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (div_valid),
    .in_mant         (div_mant),
    .out_valid       (norm_valid),
    .mantissa        (norm_mant),
    .biased_exponent (norm_exp)
  );

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (norm_valid) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        mantissa        <= skid_mant;
        biased_exponent <= skid_exp;
      end
    end else if (norm_valid) begin
      if (out_valid && !out_ready) begin
        skid_mant <= norm_mant;
        skid_exp  <= norm_exp;
      end else begin
        mantissa        <= norm_mant;
        biased_exponent <= norm_exp;
      end
    end
  end

endmodule
